// ----- rtl/core/rtufc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the RTU request framer.
// Has no dependencies; used by every module of the framer.
`default_nettype none

package rtufc_pkg;

  // Frame geometry: six body bytes followed by two CRC bytes.
  localparam int unsigned FRAME_LEN   = 8;
  localparam int unsigned BODY_LEN    = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);

  // Byte positions within a frame, in transmit order.
  localparam logic [IDX_W-1:0] POS_STATION = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_FUNC    = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_ADDR_HI = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_ADDR_LO = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_VAL_HI  = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_VAL_LO  = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_CRC_LO  = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_CRC_HI  = IDX_W'(7);

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef struct packed {
    logic [7:0]  station_address;
    logic [7:0]  function_code;
    logic [15:0] address_word;
    logic [15:0] value_word;
  } req_t;

  // One byte of the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rtufc_queue.sv -----
// Small request queue between the accepting front and the byte sequencer.
// Depends on rtufc_pkg for the request type; depth must be a power of two.
`default_nettype none

module rtufc_queue
  import rtufc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic push_i,
  input  wire  req_t push_req_i,
  output logic       full_o,
  input  wire  logic pop_i,
  output logic       head_valid_o,
  output req_t       head_req_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_req_o   = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rtufc_back.sv -----
// Byte sequencer: walks the eight frame positions of the head request,
// folds body bytes into the CRC and drives the registered output byte.
// Depends on rtufc_pkg.
`default_nettype none

module rtufc_back
  import rtufc_pkg::*;
(
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       head_valid_i,
  input  wire  req_t       head_req_i,
  output logic             pop_o,
  output logic             byte_valid_o,
  input  wire  logic       byte_ready_i,
  output logic [7:0]       frame_byte_o,
  output logic             last_byte_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic [7:0]       byte_sel;
  logic             advance;

  assign advance = head_valid_i && (!out_valid_q || byte_ready_i);

  always_comb begin
    case (idx_q)
      POS_STATION: byte_sel = head_req_i.station_address;
      POS_FUNC:    byte_sel = head_req_i.function_code;
      POS_ADDR_HI: byte_sel = head_req_i.address_word[15:8];
      POS_ADDR_LO: byte_sel = head_req_i.address_word[7:0];
      POS_VAL_HI:  byte_sel = head_req_i.value_word[15:8];
      POS_VAL_LO:  byte_sel = head_req_i.value_word[7:0];
      POS_CRC_LO:  byte_sel = crc_q[7:0];
      POS_CRC_HI:  byte_sel = crc_q[15:8];
      default:     byte_sel = '0;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !byte_ready_i;
    pop_o       = 1'b0;
    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = byte_sel;
      out_last_d  = (idx_q == POS_CRC_HI);
      idx_d       = IDX_W'(idx_q + 1'b1);
      if (idx_q == POS_CRC_HI) begin
        // Frame done: release the request and preset the CRC for the next one.
        crc_d = CRC_PRESET;
        pop_o = 1'b1;
      end else if (idx_q < IDX_W'(BODY_LEN)) begin
        crc_d = crc_byte(crc_q, byte_sel);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= POS_STATION;
      crc_q       <= CRC_PRESET;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  assign byte_valid_o = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/rtu_request_framer_crc16.sv -----
// RTU request framer with CRC-16: one request in, eight frame bytes out.
// Each accepted request is written into the queue, and its bytes then pass one by
// one through the registered output stage as the byte channel accepts them.
// A new request can be taken while earlier frames are still being sent.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
`default_nettype none

module rtu_request_framer_crc16
  import rtufc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // Request channel.
  input  wire  logic        req_valid_i,
  output logic              req_ready_o,
  input  wire  logic [7:0]  station_address_i,
  input  wire  logic [7:0]  function_code_i,
  input  wire  logic [15:0] address_word_i,
  input  wire  logic [15:0] value_word_i,
  // Frame byte channel.
  output logic              byte_valid_o,
  input  wire  logic        byte_ready_i,
  output logic [7:0]        frame_byte_o,
  output logic              last_byte_o
);

  // The front side takes a request whenever the queue has room, so a new
  // request can be accepted while the sequencer is still sending the bytes of
  // earlier ones. The request fields are packed into one queue entry; the
  // CRC is computed later, one byte per cycle while the output is not stalled.
  req_t req_in;
  req_t head_req;
  logic queue_full;
  logic head_valid;
  logic pop;

  always_comb begin
    req_in.station_address = station_address_i;
    req_in.function_code   = function_code_i;
    req_in.address_word    = address_word_i;
    req_in.value_word      = value_word_i;
  end

  assign req_ready_o = !queue_full;

  rtufc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (req_valid_i),
    .push_req_i   (req_in),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_req_o   (head_req)
  );

  // The back side sends the head request's frame through an output register.
  // It loads the next byte whenever that register is empty or being drained,
  // and releases the queue entry when it loads the CRC high byte.
  rtufc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_req_i   (head_req),
    .pop_o        (pop),
    .byte_valid_o (byte_valid_o),
    .byte_ready_i (byte_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the RTU request framer with CRC-16.
// Depends on rtufc_pkg (request struct, CRC constants) and rtu_request_framer_crc16.
// Requests go in under random bursts; each frame byte is checked against an in-bench prediction.
`default_nettype none

module tb;
  import rtufc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  // Cycles without any handshake on either channel before the run is declared hung.
  // The longest legal quiet stretch is one long receiver hold-off.
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;
  // Quiet time after the last expected byte, before the verdict.
  localparam int TAIL_CYCLES  = 24;
  localparam int RANDOM_REQS  = 216;
  localparam int MAX_REPORTS  = 10;

  // Function codes are opaque to the framer, but the common ones steer the stimulus.
  localparam logic [7:0] FC_READ_COILS     = 8'h01;
  localparam logic [7:0] FC_READ_INPUTS    = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_REG = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
  localparam logic [7:0] FC_WRITE_REG      = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS     = 8'h10;
  localparam logic [7:0] FC_NONE           = 8'h00;
  localparam logic [7:0] FC_ALL_ONES       = 8'hFF;

  // A queued request, optionally held back until every byte still due has arrived.
  typedef struct {
    req_t req;
    bit   drain_first;
  } queued_req_t;

  // One expected byte of a frame.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // Receiver readiness patterns; the receiver rotates through them at random.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        req_valid_i       = 1'b0;
  logic        req_ready_o;
  logic [7:0]  station_address_i = 8'h00;
  logic [7:0]  function_code_i   = 8'h00;
  logic [15:0] address_word_i    = 16'h0000;
  logic [15:0] value_word_i      = 16'h0000;
  logic        byte_valid_o;
  logic        byte_ready_i      = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        last_byte_o;

  queued_req_t req_backlog[$];
  frame_byte_t frame_bytes_due[$];

  // Sender state.
  req_t        offered_req;
  queued_req_t head;
  int          burst_left;
  int          gap_left;

  // Receiver state.
  rx_mode_e    rx_mode;
  int          mode_left;
  int          hold_left;
  int          next_hold_at;
  int          rx_cycle;
  int          bytes_seen;
  frame_byte_t due;

  int          mismatches;
  int          idle_cycles = 0;

  rtu_request_framer_crc16 i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_valid_i),
    .req_ready_o      (req_ready_o),
    .station_address_i(station_address_i),
    .function_code_i  (function_code_i),
    .address_word_i   (address_word_i),
    .value_word_i     (value_word_i),
    .byte_valid_o     (byte_valid_o),
    .byte_ready_i     (byte_ready_i),
    .frame_byte_o     (frame_byte_o),
    .last_byte_o      (last_byte_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Modbus CRC-16 over the six body bytes, first byte in body[47:40].
  // Each byte is folded in least significant bit first against the reflected polynomial.
  function automatic logic [15:0] modbus_crc16(input logic [47:0] body);
    logic [15:0] acc;
    acc = CRC_PRESET;
    for (int i = 5; i >= 0; i--) begin
      acc = acc ^ {8'h00, body[i*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // Appends the eight bytes that the framer must send for one accepted request.
  function automatic void predict_frame(input req_t r);
    logic [47:0] body;
    logic [15:0] crc;
    logic [7:0]  seq [FRAME_LEN];
    frame_byte_t fb;
    body   = {r.station_address, r.function_code, r.address_word, r.value_word};
    crc    = modbus_crc16(body);
    seq[0] = r.station_address;
    seq[1] = r.function_code;
    seq[2] = r.address_word[15:8];
    seq[3] = r.address_word[7:0];
    seq[4] = r.value_word[15:8];
    seq[5] = r.value_word[7:0];
    // The CRC goes out low byte first, unlike the payload words.
    seq[6] = crc[7:0];
    seq[7] = crc[15:8];
    for (int k = 0; k < FRAME_LEN; k++) begin
      fb.data = seq[k];
      fb.last = (k == FRAME_LEN - 1);
      frame_bytes_due.push_back(fb);
    end
  endfunction

  function automatic void queue_req(input logic [7:0] sa, input logic [7:0] fc,
                                    input logic [15:0] aw, input logic [15:0] vw,
                                    input bit drain_first);
    queued_req_t q;
    q.req.station_address = sa;
    q.req.function_code   = fc;
    q.req.address_word    = aw;
    q.req.value_word      = vw;
    q.drain_first         = drain_first;
    req_backlog.push_back(q);
  endfunction

  // Request driver. A request stays on the port until it is taken; a new one is only
  // presented once the port is free. Bursts of random length alternate with random gaps,
  // and a gap of zero now and then gives stretches of back-to-back requests. A request
  // flagged drain_first waits until every byte already due has come out.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (req_valid_i && req_ready_o) begin
        predict_frame(offered_req);
      end
      if (!req_valid_i || req_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid_i <= 1'b0;
        end else if (req_backlog.size() > 0 &&
                     (!req_backlog[0].drain_first || frame_bytes_due.size() == 0)) begin
          head              = req_backlog.pop_front();
          offered_req       = head.req;
          req_valid_i       <= 1'b1;
          station_address_i <= head.req.station_address;
          function_code_i   <= head.req.function_code;
          address_word_i    <= head.req.address_word;
          value_word_i      <= head.req.value_word;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Frame byte monitor and receiver. Every accepted byte is compared with the oldest
  // expected byte. Readiness follows a rotating pattern; twice during the run the
  // receiver holds off for a long stretch while the sender keeps offering requests,
  // so the framer's queue fills and it must stall the request channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ready_i <= 1'b0;
      rx_mode      = RX_STREAM;
      mode_left    = 0;
      hold_left    = 0;
      next_hold_at = 240;
      rx_cycle     = 0;
      bytes_seen   = 0;
      mismatches   = 0;
    end else begin
      rx_cycle++;
      if (byte_valid_o && byte_ready_i) begin
        bytes_seen++;
        if (frame_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected frame byte %02h last %b at %0t",
                     frame_byte_o, last_byte_o, $realtime);
          end
        end else begin
          due = frame_bytes_due.pop_front();
          if (due.data !== frame_byte_o || due.last !== last_byte_o) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("frame byte %0d: expected %02h last %b, got %02h last %b at %0t",
                       bytes_seen, due.data, due.last, frame_byte_o, last_byte_o,
                       $realtime);
            end
          end
        end
      end

      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 40);
      end else begin
        mode_left--;
      end

      if (hold_left == 0 && bytes_seen >= next_hold_at) begin
        hold_left    = LONG_HOLD;
        next_hold_at = next_hold_at + 900;
      end

      if (hold_left > 0) begin
        hold_left--;
        byte_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STREAM:   byte_ready_i <= 1'b1;
          RX_COIN:     byte_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE:   byte_ready_i <= ($urandom_range(0, 3) == 0);
          default:     byte_ready_i <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  // Counts consecutive cycles in which neither channel completes a handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid_i && req_ready_o) || (byte_valid_o && byte_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic [7:0]  sa;
    logic [7:0]  fc;
    logic [15:0] aw;
    logic [15:0] vw;

    // Directed part: field extremes, alternating bit patterns, the usual function codes,
    // and codes outside the usual set, which the framer must pass through untouched.
    queue_req(8'h00, FC_NONE,           16'h0000, 16'h0000, 1'b0);
    queue_req(8'hFF, FC_ALL_ONES,       16'hFFFF, 16'hFFFF, 1'b0);
    queue_req(8'h01, FC_READ_HOLDING,   16'h0000, 16'h000A, 1'b0);
    queue_req(8'h11, FC_WRITE_REG,      16'h0001, 16'h0003, 1'b0);
    // Sender pause: this one waits until all earlier frames are out.
    queue_req(8'h01, FC_WRITE_REGS,     16'hAAAA, 16'h5555, 1'b1);
    queue_req(8'h55, 8'hAA,             16'h5555, 16'hAAAA, 1'b0);
    queue_req(8'hF7, FC_READ_INPUT_REG, 16'h8000, 16'h0001, 1'b0);
    queue_req(8'h80, FC_READ_COILS,     16'h0001, 16'h8000, 1'b0);
    queue_req(8'h00, FC_ALL_ONES,       16'h00FF, 16'hFF00, 1'b0);
    queue_req(8'hFF, FC_NONE,           16'hFF00, 16'h00FF, 1'b0);
    queue_req(8'h02, FC_WRITE_COIL,     16'h00AC, 16'hFF00, 1'b0);
    queue_req(8'h7F, FC_WRITE_COILS,    16'h1234, 16'hABCD, 1'b0);
    queue_req(8'h01, FC_READ_INPUTS,    16'hFFFF, 16'h0000, 1'b0);
    queue_req(8'h01, FC_READ_HOLDING,   16'h0000, 16'hFFFF, 1'b0);
    queue_req(8'hF8, 8'h2B,             16'h0E01, 16'h0000, 1'b0);

    // Random part: mostly plausible requests, with a share of arbitrary bytes in
    // every field, and an occasional pause until the framer has drained.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      sa = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(1, 247)) : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       fc = FC_READ_COILS;
          1:       fc = FC_READ_INPUTS;
          2:       fc = FC_READ_HOLDING;
          3:       fc = FC_READ_INPUT_REG;
          4:       fc = FC_WRITE_COIL;
          5:       fc = FC_WRITE_REG;
          6:       fc = FC_WRITE_COILS;
          default: fc = FC_WRITE_REGS;
        endcase
      end else begin
        fc = 8'($urandom_range(0, 255));
      end
      aw = 16'($urandom_range(0, 65535));
      if ((fc == FC_READ_HOLDING || fc == FC_READ_INPUT_REG) && $urandom_range(0, 1) == 0) begin
        vw = 16'($urandom_range(1, 125));
      end else begin
        vw = 16'($urandom_range(0, 65535));
      end
      queue_req(sa, fc, aw, vw, ($urandom_range(0, 49) == 0));
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || req_valid_i) @(posedge clk_i);
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    // Let any stray extra byte show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- rtu_request_framer_crc16.f -----
rtl/core/rtufc_pkg.sv
rtl/core/rtufc_queue.sv
rtl/core/rtufc_back.sv
rtl/core/rtu_request_framer_crc16.sv
sim/tb.sv
